// ----- rtl/pcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// pcbp_pkg: shared types and constants for the program counter and predictor
// Field widths, action codes, hash function and inter-module structs.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  // Both sizes must be powers of two: the index and the queue slot are
  // taken as the low bits of a wider value.
  localparam int TABLE_SIZE  = 256;
  localparam int QUEUE_DEPTH = 8;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W     = 32;
  localparam int IN_DATA_W  = 40;   // target, taken, zero fill
  localparam int OUT_DATA_W = 104;  // three addresses, three flags, zero fill

  localparam logic [ADDR_W-1:0] HASH_KEY = 32'd82589046;
  localparam logic [ADDR_W-1:0] PC_STEP  = 32'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [1:0]        ctr_t;

  localparam ctr_t CTR_RESET = 2'd1;  // weakly not taken
  localparam ctr_t CTR_MAX   = 2'd3;
  localparam ctr_t CTR_MIN   = 2'd0;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_PREDICT = 2'd2,
    ACT_RESOLVE = 2'd3
  } action_t;

  // Counter table write port.
  typedef struct packed {
    logic en;
    idx_t addr;
    ctr_t data;
  } tbl_wr_t;

  // Requests from the execute logic to the branch queue.
  typedef struct packed {
    logic push;
    idx_t push_index;
    logic push_guess;
    logic pop;
    logic flush;
  } q_ctrl_t;

  // Queue status back to the execute logic.
  typedef struct packed {
    logic full;
    logic empty;
    logic head_guess;
    idx_t look_index;  // table index at the head after this cycle's update
  } q_stat_t;

  // 32-bit xorshift around a fixed key.
  function automatic addr_t pc_hash(input addr_t pc);
    addr_t x;
    x = pc ^ HASH_KEY;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x ^ HASH_KEY;
  endfunction

endpackage

// ----- rtl/pcbp_table.sv -----
// ----------------------------------------------------------------------------
// pcbp_table: two-bit counter table
// One write and one registered read per cycle; a read of the address being
// written returns the new value. Valid bits give the reset value.
// ----------------------------------------------------------------------------
module pcbp_table
  import pcbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    rd_en,
  input  idx_t    rd_addr,
  output ctr_t    rd_data,
  input  tbl_wr_t wr
);

  ctr_t                  mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= CTR_RESET;
      end
    end
  end

endmodule

// ----- rtl/pcbp_queue.sv -----
// ----------------------------------------------------------------------------
// pcbp_queue: queue of branches waiting for resolution
// Holds table index and guess per branch; head and fill count in flops.
// ----------------------------------------------------------------------------
module pcbp_queue
  import pcbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_ctrl_t ctrl,
  output q_stat_t stat
);

  idx_t pend_index [QUEUE_DEPTH];
  logic pend_guess [QUEUE_DEPTH];
  ptr_t head;
  cnt_t count;
  ptr_t head_next;
  cnt_t count_next;
  ptr_t tail;

  assign tail      = head + count[PTR_W-1:0];
  assign head_next = ctrl.pop ? head + ptr_t'(1) : head;

  always_comb begin
    if (ctrl.flush) begin
      count_next = '0;
    end else if (ctrl.push) begin
      count_next = count + cnt_t'(1);
    end else if (ctrl.pop) begin
      count_next = count - cnt_t'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      pend_index[tail] <= ctrl.push_index;
      pend_guess[tail] <= ctrl.push_guess;
    end
  end

  // Forward an entry written this cycle into the slot that becomes the head.
  always_comb begin
    stat.full       = (count == cnt_t'(QUEUE_DEPTH));
    stat.empty      = (count == '0);
    stat.head_guess = pend_guess[head];
    if (ctrl.push && (tail == head_next)) begin
      stat.look_index = ctrl.push_index;
    end else begin
      stat.look_index = pend_index[head_next];
    end
  end

endmodule

// ----- rtl/pc_with_bimodal_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// pc_with_bimodal_branch_predictor: program counter with bimodal predictor
// Set, advance, predict and resolve actions on a program counter pair, with
// a table of two-bit saturating counters and a queue of open branches.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                    | Payload
// ---------+-----+------------------------------+---------------------------
// s_axis   | in  | s_axis_tvalid / tready       | tuser: action; tdata: target, taken
// m_axis   | out | m_axis_tvalid / tready       | tdata: pc_now, pc_next, alt_address,
//          |     |                              |   predicted_taken, prediction_correct,
//          |     |                              |   queue_error
//
// One request per cycle unless the output stalls: the request is registered
// together with its counter table read, then executed into the result
// register. Sustained rate is one request per cycle; the loop that sets it
// is the state update feeding the next table read address.
// Reset (rst, synchronous) zeroes both addresses, empties the queue and marks
// every counter weakly not taken at once. A stalled result holds the request
// behind it, and s_axis_tready drops only while both stages are full.
// ----------------------------------------------------------------------------
module pc_with_bimodal_branch_predictor
  import pcbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] target, [32] taken
  input  logic [1:0]            s_axis_tuser,  // [1:0] action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [31:0] pc_now, [63:32] pc_next,
                                               // [95:64] alt_address,
                                               // [96] predicted_taken,
                                               // [97] prediction_correct,
                                               // [98] queue_error
);

  // Architectural state.
  addr_t   cur_pc;
  addr_t   upc_pc;
  addr_t   cur_pc_next;
  addr_t   upc_pc_next;

  // Execute stage: the accepted request and its table read.
  logic    ex_valid;
  action_t ex_action;
  addr_t   ex_target;
  logic    ex_taken;
  idx_t    ex_idx;
  logic    ex_fire;
  logic    in_accept;

  // Result register.
  logic    out_valid;
  addr_t   out_pc_now;
  addr_t   out_pc_next;
  addr_t   out_alt;
  logic    out_guess;
  logic    out_correct;
  logic    out_err;

  // Execute results.
  addr_t   res_alt;
  logic    res_guess;
  logic    res_correct;
  logic    res_err;
  ctr_t    ctr;
  ctr_t    ctr_upd;
  addr_t   cur_plus4;

  tbl_wr_t tbl_wr;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;

  // Table read address for the incoming request.
  action_t in_action;
  addr_t   cur_after;
  addr_t   in_hash;
  idx_t    rd_addr;

  // Move the request forward whenever the result slot is free or draining.
  assign ex_fire       = ex_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !ex_valid || ex_fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign cur_plus4 = cur_pc + PC_STEP;

  // Saturate the counter toward the outcome.
  always_comb begin
    if (ex_taken) begin
      ctr_upd = (ctr == CTR_MAX) ? ctr : ctr + ctr_t'(1);
    end else begin
      ctr_upd = (ctr == CTR_MIN) ? ctr : ctr - ctr_t'(1);
    end
  end

  always_comb begin
    cur_pc_next = cur_pc;
    upc_pc_next = upc_pc;
    res_alt     = '0;
    res_guess   = 1'b0;
    res_correct = 1'b0;
    res_err     = 1'b0;
    tbl_wr      = '0;
    q_ctrl      = '0;
    case (ex_action)
      ACT_SET: begin
        upc_pc_next = ex_target;
      end
      ACT_ADVANCE: begin
        cur_pc_next = upc_pc;
        upc_pc_next = upc_pc + PC_STEP;
      end
      ACT_PREDICT: begin
        if (q_stat.full) begin
          res_err = 1'b1;
        end else begin
          res_guess         = ctr[1];
          q_ctrl.push       = ex_fire;
          q_ctrl.push_index = ex_idx;
          q_ctrl.push_guess = ctr[1];
          upc_pc_next       = ctr[1] ? ex_target : cur_plus4;
          res_alt           = ctr[1] ? cur_plus4 : ex_target;
        end
      end
      ACT_RESOLVE: begin
        if (q_stat.empty) begin
          res_err = 1'b1;
        end else begin
          res_correct  = (q_stat.head_guess == ex_taken);
          tbl_wr.en    = ex_fire;
          tbl_wr.addr  = ex_idx;
          tbl_wr.data  = ctr_upd;
          q_ctrl.pop   = ex_fire;
          // Drop every open branch on a miss.
          q_ctrl.flush = ex_fire && (q_stat.head_guess != ex_taken);
        end
      end
      default: begin
        res_err = 1'b0;
      end
    endcase
  end

  // Address the table with the state as it stands once the request ahead
  // has executed.
  assign in_action = action_t'(s_axis_tuser);
  assign cur_after = ex_fire ? cur_pc_next : cur_pc;
  assign in_hash   = pc_hash(cur_after);
  assign rd_addr   = (in_action == ACT_PREDICT) ? in_hash[IDX_W-1:0] : q_stat.look_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pc    <= '0;
      upc_pc    <= '0;
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ex_fire) begin
        cur_pc <= cur_pc_next;
        upc_pc <= upc_pc_next;
      end
      if (in_accept) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_action <= in_action;
      ex_target <= s_axis_tdata[31:0];
      ex_taken  <= s_axis_tdata[32];
      ex_idx    <= rd_addr;
    end
    if (ex_fire) begin
      out_pc_now  <= cur_pc_next;
      out_pc_next <= upc_pc_next;
      out_alt     <= res_alt;
      out_guess   <= res_guess;
      out_correct <= res_correct;
      out_err     <= res_err;
    end
  end

  pcbp_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (ctr),
    .wr      (tbl_wr)
  );

  pcbp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (q_ctrl),
    .stat (q_stat)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_err, out_correct, out_guess,
                          out_alt, out_pc_next, out_pc_now};

endmodule

// ----- rtl/pcbp_checker.sv -----
// ----------------------------------------------------------------------------
// pcbp_checker: port-level checks for the program counter block
// Result flag consistency, output hold under stall, reset and latency.
// ----------------------------------------------------------------------------
module pcbp_checker
  import pcbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A failed request carries neither a guess nor a verdict.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[98] |-> !m_axis_tdata[96] && !m_axis_tdata[97]
      && (m_axis_tdata[95:64] == '0))
    else $error("error result with prediction fields set");

  // A result is either a prediction or a resolution, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[96] && m_axis_tdata[97]))
    else $error("guess and verdict in one result");

  // Accept requests right after reset.
  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("not ready after reset");

  // A fresh result traces back to an accepted request, via the execute stage and the result register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a request");

endmodule

bind pc_with_bimodal_branch_predictor pcbp_checker u_pcbp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the program counter with bimodal predictor
// Drives set, advance, predict and resolve requests into the stream input,
// keeps its own copy of the pc pair, counter table and open-branch queue,
// and checks every result word field by field against that copy. Random
// idle bursts on both sides, a long output hold-off and a full drain pause
// exercise the handshake.
// ----------------------------------------------------------------------------
module tb;
  import pcbp_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 60;

  // One result word, split into its fields.
  typedef struct {
    addr_t pc_now;
    addr_t pc_next;
    addr_t alt_address;
    logic  predicted_taken;
    logic  prediction_correct;
    logic  queue_error;
  } fetch_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // [31:0] target, [32] taken
  logic [1:0]            s_axis_tuser = '0;  // [1:0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // [31:0] pc_now, [63:32] pc_next,
                                             // [95:64] alt_address,
                                             // [96] predicted_taken,
                                             // [97] prediction_correct,
                                             // [98] queue_error

  pc_with_bimodal_branch_predictor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Expected behavior: pc pair, counter table and queue of open branches
  // --------------------------------------------------------------------------
  addr_t pc_cur;
  addr_t pc_upc;
  ctr_t  ctr_tbl [TABLE_SIZE];
  idx_t  open_idx [QUEUE_DEPTH];
  logic  open_guess [QUEUE_DEPTH];
  ptr_t  open_head;
  int    open_count;

  fetch_result_t results_due[$];

  // Run statistics for the closing summary.
  int n_reqs, n_predicts, n_resolves, n_hits, n_flushes, n_qerrs, n_seen;
  int errors;

  // Addresses that recur often, so table entries get trained and retrained.
  addr_t hot_pc [8];

  // Control shared with the idle processes.
  bit src_idle;
  bit sink_idle;
  int hold_ask;

  function automatic void clear_model();
    pc_cur = '0;
    pc_upc = '0;
    foreach (ctr_tbl[i]) ctr_tbl[i] = CTR_RESET;
    open_head  = '0;
    open_count = 0;
  endfunction

  // Xorshift around the fixed key, then reduced to a table index.
  function automatic idx_t table_index(addr_t pc);
    logic [31:0] s;
    s = pc ^ HASH_KEY;
    s = s ^ (s << 13);
    s = s ^ (s >> 7);
    s = s ^ (s << 17);
    s = s ^ HASH_KEY;
    return idx_t'(s % TABLE_SIZE);
  endfunction

  // Apply one request to the expected state and return the result it causes.
  function automatic fetch_result_t fetch_step(action_t act, addr_t tgt, logic tk);
    fetch_result_t r;
    idx_t idx;
    ptr_t slot;
    ctr_t c;
    logic g;
    r = '{default: '0};
    case (act)
      ACT_SET: begin
        pc_upc = tgt;
      end
      ACT_ADVANCE: begin
        pc_cur = pc_upc;
        pc_upc = pc_cur + PC_STEP;
      end
      ACT_PREDICT: begin
        if (open_count >= QUEUE_DEPTH) begin
          // Full queue: flag it and leave everything alone.
          r.queue_error = 1'b1;
        end else begin
          idx  = table_index(pc_cur);
          slot = ptr_t'((open_head + open_count) % QUEUE_DEPTH);
          g    = (ctr_tbl[idx] > 2'd1);
          open_idx[slot]   = idx;
          open_guess[slot] = g;
          open_count++;
          if (g) begin
            pc_upc        = tgt;
            r.alt_address = pc_cur + PC_STEP;
          end else begin
            pc_upc        = pc_cur + PC_STEP;
            r.alt_address = tgt;
          end
          r.predicted_taken = g;
        end
      end
      ACT_RESOLVE: begin
        if (open_count == 0) begin
          r.queue_error = 1'b1;
        end else begin
          idx = open_idx[open_head];
          g   = open_guess[open_head];
          c   = ctr_tbl[idx];
          if (tk) begin
            if (c != CTR_MAX) c++;
          end else begin
            if (c != CTR_MIN) c--;
          end
          ctr_tbl[idx] = c;
          open_head = ptr_t'((open_head + 1) % QUEUE_DEPTH);
          open_count--;
          r.prediction_correct = (g == tk);
          // A miss flushes every open branch; the head is not reset.
          if (g != tk) begin
            open_count = 0;
            n_flushes++;
          end
        end
      end
    endcase
    r.pc_now  = pc_cur;
    r.pc_next = pc_upc;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: one request per call, held until the block takes it
  // --------------------------------------------------------------------------
  task automatic send_req(action_t act, addr_t tgt, logic tk);
    fetch_result_t r;
    int gap;
    // Idle burst: at random, drop valid before the next request.
    if (src_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'b0, tk, tgt};
    do @(posedge clk); while (!s_axis_tready);
    // Accepted at this edge: book the result it must produce.
    r = fetch_step(act, tgt, tk);
    results_due.push_back(r);
    n_reqs++;
    if (act == ACT_PREDICT) n_predicts++;
    if (act == ACT_RESOLVE) n_resolves++;
    if (act == ACT_RESOLVE && r.prediction_correct) n_hits++;
    if (r.queue_error) n_qerrs++;
  endtask

  // Drop valid, then hold until every booked result has come back.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts and an occasional long hold-off
  // --------------------------------------------------------------------------
  int hold_seen;
  int hold_left;
  int stall_left;

  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen     <= hold_ask;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest booked one.
  always @(posedge clk) begin : check_results
    fetch_result_t want;
    fetch_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pc_now             = m_axis_tdata[31:0];
      got.pc_next            = m_axis_tdata[63:32];
      got.alt_address        = m_axis_tdata[95:64];
      got.predicted_taken    = m_axis_tdata[96];
      got.prediction_correct = m_axis_tdata[97];
      got.queue_error        = m_axis_tdata[98];
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        n_seen++;
        if (got.pc_now !== want.pc_now) begin
          $error("pc_now: expected %h, got %h", want.pc_now, got.pc_now);
          errors++;
        end
        if (got.pc_next !== want.pc_next) begin
          $error("pc_next: expected %h, got %h", want.pc_next, got.pc_next);
          errors++;
        end
        if (got.alt_address !== want.alt_address) begin
          $error("alt_address: expected %h, got %h", want.alt_address, got.alt_address);
          errors++;
        end
        if (got.predicted_taken !== want.predicted_taken) begin
          $error("predicted_taken: expected %b, got %b",
                 want.predicted_taken, got.predicted_taken);
          errors++;
        end
        if (got.prediction_correct !== want.prediction_correct) begin
          $error("prediction_correct: expected %b, got %b",
                 want.prediction_correct, got.prediction_correct);
          errors++;
        end
        if (got.queue_error !== want.queue_error) begin
          $error("queue_error: expected %b, got %b", want.queue_error, got.queue_error);
          errors++;
        end
      end
    end
  end

  // Watchdog on total run length.
  int cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked requests: empty and full queue, wrap of the pc, counter
  // saturation at the top and a walk to the bottom, flush on a miss, extreme targets.
  task automatic test_directed();
    src_idle  = 0;
    sink_idle = 0;
    send_req(ACT_RESOLVE, 32'hFFFF_FFFF, 1'b1);  // resolve with nothing open
    send_req(ACT_ADVANCE, 32'h0, 1'b0);
    send_req(ACT_ADVANCE, 32'hFFFF_FFFF, 1'b1);
    send_req(ACT_SET, 32'hFFFF_FFFC, 1'b0);
    send_req(ACT_ADVANCE, 32'h0, 1'b0);          // next address wraps to zero
    send_req(ACT_PREDICT, 32'hFFFF_FFFF, 1'b0);  // weakly not taken
    send_req(ACT_RESOLVE, 32'h0, 1'b1);          // miss, flush, counter up
    send_req(ACT_PREDICT, 32'h0, 1'b1);          // now predicted taken
    send_req(ACT_RESOLVE, 32'h0, 1'b1);          // hit, counter saturates high
    send_req(ACT_PREDICT, 32'h8000_0000, 1'b0);
    send_req(ACT_RESOLVE, 32'h0, 1'b1);          // stays at the top
    // Fill the queue, then one more predict must be refused.
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      send_req(ACT_PREDICT, addr_t'($urandom), 1'(i));
    // Resolve against the guess: miss flushes the rest.
    send_req(ACT_RESOLVE, 32'h0, ~open_guess[open_head]);
    send_req(ACT_RESOLVE, 32'h0, 1'b0);          // empty again after the flush
    // Walk the same counter down to the bottom.
    repeat (2) begin
      send_req(ACT_PREDICT, 32'h1234_5678, 1'b0);
      send_req(ACT_RESOLVE, 32'h0, 1'b0);
    end
    wait_drained();
  endtask

  // Mostly well-formed predict / resolve traffic over a small address pool,
  // with a little noise: resolves on an empty queue and predicts on a full one.
  task automatic run_random(int n_items);
    int     r;
    action_t act;
    addr_t  tgt;
    logic   tk;
    for (int i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 99);
      tgt = ($urandom_range(0, 3) == 0) ? addr_t'($urandom) : hot_pc[$urandom_range(0, 7)];
      tk  = 1'($urandom_range(0, 1));
      if (r < 10) act = ACT_SET;
      else if (r < 35) act = ACT_ADVANCE;
      else if (r < 68) act = ACT_PREDICT;
      else act = ACT_RESOLVE;
      if (act == ACT_RESOLVE && open_count == 0 && $urandom_range(0, 9) != 0)
        act = ACT_PREDICT;
      if (act == ACT_PREDICT && open_count == QUEUE_DEPTH && $urandom_range(0, 9) != 0)
        act = ACT_RESOLVE;
      // Bias outcomes toward the guess so runs of hits build up.
      if (act == ACT_RESOLVE && open_count != 0 && $urandom_range(0, 3) != 0)
        tk = open_guess[open_head];
      send_req(act, tgt, tk);
    end
  endtask

  task automatic test_random_idle();
    src_idle  = 1;
    sink_idle = 1;
    run_random(600);
  endtask

  // Hold the result side for a long stretch while requests keep coming, so
  // both stages fill and the input stalls; then pause until all results land.
  task automatic test_backpressure();
    src_idle  = 0;
    sink_idle = 0;
    hold_ask++;
    run_random(40);
    wait_drained();
    run_random(40);
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    src_idle  = 0;
    sink_idle = 0;
    run_random(250);
  endtask

  initial begin
    clear_model();
    hot_pc[0] = 32'h0000_0000;
    hot_pc[1] = 32'hFFFF_FFFC;
    for (int i = 2; i < 8; i++) hot_pc[i] = addr_t'($urandom) & ~32'h3;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_idle();
    test_backpressure();
    test_random_idle();
    test_full_rate();

    // Drop valid, wait for the last results, then let the pipe settle.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d predicts, %0d resolves",
             n_reqs, n_seen, n_predicts, n_resolves);
    $display("  %0d correct guesses, %0d flushes, %0d queue errors, %0d mismatches",
             n_hits, n_flushes, n_qerrs, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- pc_with_bimodal_branch_predictor.f -----
rtl/pcbp_pkg.sv
rtl/pcbp_table.sv
rtl/pcbp_queue.sv
rtl/pc_with_bimodal_branch_predictor.sv
rtl/pcbp_checker.sv
tb/sv/tb.sv
